FILE: hw/rtl/vrwm_pkg.sv
// Shared types and constants for the velocity ramp / wheel mixer.
// Used by vrwm_cfg_regs, vrwm_arith_unit and velocity_ramp_wheel_mixer_core.
`default_nettype none

package vrwm_pkg;

  localparam int unsigned SPEED_WIDTH_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  localparam int unsigned IN_WIDTH        = 24;
  localparam int unsigned REF_WIDTH       = 24;
  localparam int unsigned RAMP_WIDTH      = 16;
  localparam int unsigned MIN_STEP_WIDTH  = 23;
  localparam int unsigned GAIN_WIDTH      = 24;
  localparam int unsigned GAIN_FRAC       = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 3;
  localparam int unsigned CFG_DATA_WIDTH  = 24;

  localparam logic [RAMP_WIDTH-1:0]     RAMP_STEPS_RST = RAMP_WIDTH'(300);
  localparam logic [MIN_STEP_WIDTH-1:0] MIN_STEP_RST   = MIN_STEP_WIDTH'(1);
  localparam logic [GAIN_WIDTH-1:0]     GAIN_ONE       = GAIN_WIDTH'(65536);

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_RAMP_STEPS    = 3'd0,
    CFG_MIN_LIN_STEP  = 3'd1,
    CFG_MIN_ANG_STEP  = 3'd2,
    CFG_LEFT_GAIN     = 3'd3,
    CFG_RIGHT_GAIN    = 3'd4,
    CFG_TURN_COUPLING = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [RAMP_WIDTH-1:0]     ramp_steps;
    logic [MIN_STEP_WIDTH-1:0] min_lin_step;
    logic [MIN_STEP_WIDTH-1:0] min_ang_step;
    logic [GAIN_WIDTH-1:0]     left_gain;
    logic [GAIN_WIDTH-1:0]     right_gain;
    logic [GAIN_WIDTH-1:0]     turn_coupling;
  } cfg_regs_t;

  typedef enum logic {
    MODE_MUL = 1'b0,
    MODE_DIV = 1'b1
  } unit_mode_t;

  typedef struct packed {
    logic       start;
    unit_mode_t mode;
  } arith_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/velocity_ramp_wheel_mixer_core.sv
// Velocity ramp and differential-drive wheel mixer, top level.
// Depends on vrwm_pkg, vrwm_cfg_regs and vrwm_arith_unit.
//
// One word is taken at a time; in_ready is high only while the block is idle. A set
// word (op 0) stores the targets and runs two serial divisions through the shared
// arithmetic unit, one quotient bit per cycle, and it returns nothing. A tick word
// (op 1) ramps the linear and then the angular speed, then runs three serial
// multiplies (angular speed times coupling, then each wheel sum times its gain), one
// multiplier bit per cycle, and then holds its result while an earlier one still waits.
// The result is held in an output register, so a new word is taken while it waits.
// Configuration writes are taken every cycle and belong only in idle periods.
`default_nettype none

module velocity_ramp_wheel_mixer_core import vrwm_pkg::*; #(
  parameter int unsigned SPEED_WIDTH = SPEED_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic signed [IN_WIDTH-1:0] target_lin,
  input  logic signed [IN_WIDTH-1:0] target_ang,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [REF_WIDTH-1:0] left_ref,
  output logic signed [REF_WIDTH-1:0] right_ref,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int unsigned W     = SPEED_WIDTH;
  localparam int unsigned DW    = W + 1;
  localparam int unsigned MW    = W + GAIN_WIDTH;
  localparam int unsigned PW    = MW + GAIN_WIDTH;
  localparam int unsigned SUMW  = MW + 2;
  localparam int unsigned SHIFT = FRAC_BITS + 2 * GAIN_FRAC;
  localparam int unsigned HIW   = PW - SHIFT;
  localparam int unsigned RX    = ((HIW > REF_WIDTH) ? HIW : REF_WIDTH) + 1;
  localparam int unsigned XW    = ((W > IN_WIDTH) ? W : IN_WIDTH) + 1;
  localparam int unsigned EW    = ((DW > MIN_STEP_WIDTH) ? DW : MIN_STEP_WIDTH) + 1;

  localparam logic [EW-1:0] SLIM_POS = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [RX-1:0] RLIM_POS = {{(RX-REF_WIDTH+1){1'b0}}, {(REF_WIDTH-1){1'b1}}};
  localparam logic [W-1:0]  SPD_MAX  = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DIV_LIN  = 9'b000000010,
    S_DIV_ANG  = 9'b000000100,
    S_RAMP_LIN = 9'b000001000,
    S_RAMP_ANG = 9'b000010000,
    S_MUL_W    = 9'b000100000,
    S_MUL_L    = 9'b001000000,
    S_MUL_R    = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  function automatic logic [W-1:0] sat_target(input logic [IN_WIDTH-1:0] t);
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    logic [W-1:0]         r;
    x  = {{(XW-IN_WIDTH){t[IN_WIDTH-1]}}, t};
    hi = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      r = hi[W-1:0];
    end else if (x < lo) begin
      r = lo[W-1:0];
    end else begin
      r = x[W-1:0];
    end
    return r;
  endfunction

  state_t state;
  state_t state_next;
  logic   launch;
  logic   launch_next;

  logic [W-1:0] cur_lin;
  logic [W-1:0] cur_ang;
  logic [W-1:0] goal_lin;
  logic [W-1:0] goal_ang;
  logic [W-1:0] step_lin;
  logic [W-1:0] step_ang;

  logic [MW-1:0]        b_mag;
  logic [REF_WIDTH-1:0] left_hold;

  cfg_regs_t   cfg;
  arith_cmd_t  cmd;
  arith_stat_t stat;
  logic [MW-1:0]         mcand;
  logic [GAIN_WIDTH-1:0] mplier;
  logic [RAMP_WIDTH-1:0] divisor;
  logic [PW-1:0]         prod;

  logic         sel_ang;
  logic [W-1:0] goal_sel;
  logic [W-1:0] cur_sel;
  logic [W-1:0] step_sel;
  logic [W:0]   diff;
  logic         diff_neg;
  logic [W:0]   diff_mag;

  logic [MIN_STEP_WIDTH-1:0] min_sel;
  logic [EW-1:0] q_ext;
  logic [EW-1:0] min_ext;
  logic [EW-1:0] s_mag;
  logic [EW-1:0] s_lim;
  logic [EW-1:0] s_sat;
  logic [W-1:0]  step_new;

  logic [W:0]   step_ext;
  logic [W:0]   step_mag;
  logic [W:0]   ramp_sum;
  logic [W-1:0] ramp_sat;
  logic [W-1:0] cur_new;

  logic [W:0]      v_ext;
  logic [W:0]      w_ext;
  logic [W:0]      v_abs;
  logic [W:0]      w_abs;
  logic [SUMW-1:0] a_term;
  logic [SUMW-1:0] b_term;
  logic [SUMW-1:0] sv;
  logic [SUMW-1:0] sw;
  logic [SUMW-1:0] left_sum;
  logic [SUMW-1:0] right_sum;
  logic [SUMW-1:0] left_abs;
  logic [SUMW-1:0] right_abs;
  logic            left_neg;
  logic            right_neg;

  logic                 wneg;
  logic [RX-1:0]        hi_ext;
  logic [RX-1:0]        r_lim;
  logic [RX-1:0]        r_sat;
  logic [REF_WIDTH-1:0] wheel;

  vrwm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vrwm_arith_unit #(
    .MCAND_WIDTH (MW),
    .DIVD_WIDTH  (DW)
  ) u_arith (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .mcand    (mcand),
    .mplier   (mplier),
    .dividend (diff_mag),
    .divisor  (divisor),
    .stat     (stat),
    .prod     (prod)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // target minus current, shared by step computation and ramp
  assign sel_ang  = (state == S_DIV_ANG) || (state == S_RAMP_ANG);
  assign goal_sel = sel_ang ? goal_ang : goal_lin;
  assign cur_sel  = sel_ang ? cur_ang : cur_lin;
  assign step_sel = sel_ang ? step_ang : step_lin;
  assign diff     = {goal_sel[W-1], goal_sel} - {cur_sel[W-1], cur_sel};
  assign diff_neg = diff[W];
  assign diff_mag = diff_neg ? -diff : diff;

  assign divisor = (cfg.ramp_steps == '0) ? RAMP_WIDTH'(1) : cfg.ramp_steps;

  // quotient to step: minimum step, then saturate
  assign min_sel  = sel_ang ? cfg.min_ang_step : cfg.min_lin_step;
  assign q_ext    = {{(EW-DW){1'b0}}, prod[DW-1:0]};
  assign min_ext  = {{(EW-MIN_STEP_WIDTH){1'b0}}, min_sel};
  assign s_mag    = ((diff != '0) && (q_ext < min_ext)) ? min_ext : q_ext;
  assign s_lim    = diff_neg ? SLIM_POS + EW'(1) : SLIM_POS;
  assign s_sat    = (s_mag > s_lim) ? s_lim : s_mag;
  assign step_new = diff_neg ? -s_sat[W-1:0] : s_sat[W-1:0];

  // ramp one tick
  assign step_ext = {step_sel[W-1], step_sel};
  assign step_mag = step_ext[W] ? -step_ext : step_ext;
  assign ramp_sum = {cur_sel[W-1], cur_sel} + step_ext;
  assign ramp_sat = (ramp_sum[W] != ramp_sum[W-1]) ? (ramp_sum[W] ? ~SPD_MAX : SPD_MAX)
                                                   : ramp_sum[W-1:0];
  assign cur_new  = (diff_mag <= step_mag) ? goal_sel : ramp_sat;

  // wheel sums at Q(FRAC_BITS+16)
  assign v_ext     = {cur_lin[W-1], cur_lin};
  assign w_ext     = {cur_ang[W-1], cur_ang};
  assign v_abs     = v_ext[W] ? -v_ext : v_ext;
  assign w_abs     = w_ext[W] ? -w_ext : w_ext;
  assign a_term    = {{(SUMW-W-GAIN_FRAC){1'b0}}, v_abs[W-1:0], {GAIN_FRAC{1'b0}}};
  assign b_term    = {2'b00, b_mag};
  assign sv        = cur_lin[W-1] ? -a_term : a_term;
  assign sw        = cur_ang[W-1] ? -b_term : b_term;
  assign left_sum  = sw - sv;
  assign right_sum = sv + sw;
  assign left_neg  = left_sum[SUMW-1];
  assign right_neg = right_sum[SUMW-1];
  assign left_abs  = left_neg ? -left_sum : left_sum;
  assign right_abs = right_neg ? -right_sum : right_sum;

  always_comb begin
    case (state)
      S_MUL_W: begin
        mcand  = {{(MW-W){1'b0}}, w_abs[W-1:0]};
        mplier = cfg.turn_coupling;
      end
      S_MUL_L: begin
        mcand  = left_abs[MW-1:0];
        mplier = cfg.left_gain;
      end
      default: begin
        mcand  = right_abs[MW-1:0];
        mplier = cfg.right_gain;
      end
    endcase
  end

  assign cmd.start = launch;
  assign cmd.mode  = ((state == S_DIV_LIN) || (state == S_DIV_ANG)) ? MODE_DIV : MODE_MUL;

  // product to reference: truncate toward zero, saturate
  assign wneg   = (state == S_MUL_L) ? left_neg : right_neg;
  assign hi_ext = {{(RX-HIW){1'b0}}, prod[PW-1:SHIFT]};
  assign r_lim  = wneg ? RLIM_POS + RX'(1) : RLIM_POS;
  assign r_sat  = (hi_ext > r_lim) ? r_lim : hi_ext;
  assign wheel  = wneg ? -r_sat[REF_WIDTH-1:0] : r_sat[REF_WIDTH-1:0];

  always_comb begin
    state_next  = state;
    launch_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_SET) begin
            state_next  = S_DIV_LIN;
            launch_next = 1'b1;
          end else begin
            state_next = S_RAMP_LIN;
          end
        end
      end
      S_DIV_LIN: begin
        if (stat.done) begin
          state_next  = S_DIV_ANG;
          launch_next = 1'b1;
        end
      end
      S_DIV_ANG: begin
        if (stat.done) begin
          state_next = S_IDLE;
        end
      end
      S_RAMP_LIN: state_next = S_RAMP_ANG;
      S_RAMP_ANG: begin
        state_next  = S_MUL_W;
        launch_next = 1'b1;
      end
      S_MUL_W: begin
        if (stat.done) begin
          state_next  = S_MUL_L;
          launch_next = 1'b1;
        end
      end
      S_MUL_L: begin
        if (stat.done) begin
          state_next  = S_MUL_R;
          launch_next = 1'b1;
        end
      end
      S_MUL_R: begin
        if (stat.done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      out_valid <= 1'b0;
      cur_lin   <= '0;
      cur_ang   <= '0;
      goal_lin  <= '0;
      goal_ang  <= '0;
      step_lin  <= '0;
      step_ang  <= '0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && (op == OP_SET)) begin
            goal_lin <= sat_target(target_lin);
            goal_ang <= sat_target(target_ang);
          end
        end
        S_DIV_LIN: begin
          if (stat.done) begin
            step_lin <= step_new;
          end
        end
        S_DIV_ANG: begin
          if (stat.done) begin
            step_ang <= step_new;
          end
        end
        S_RAMP_LIN: cur_lin <= cur_new;
        S_RAMP_ANG: cur_ang <= cur_new;
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_MUL_W) && stat.done) begin
      b_mag <= prod[MW-1:0];
    end
    if ((state == S_MUL_L) && stat.done) begin
      left_hold <= wheel;
    end
    if ((state == S_FINISH) && (!out_valid || out_ready)) begin
      left_ref  <= left_hold;
      right_ref <= wheel;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_in_work: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !(state == S_IDLE || state == S_FINISH ||
                    state == S_RAMP_LIN || state == S_RAMP_ANG))
    else $error("arith unit finished outside a waiting state");

  a_launch_busy: assert property (@(posedge clk) disable iff (rst)
    launch |=> stat.busy)
    else $error("arith unit did not start after launch");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !in_ready)
    else $error("input ready while arith unit busy");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished tick did not load the output register");

  a_set_starts_div: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == OP_SET) |=> (state == S_DIV_LIN && launch))
    else $error("set word did not start the step division");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/vrwm_cfg_regs.sv
// Configuration register file for the velocity ramp / wheel mixer.
// Depends on vrwm_pkg for register indexes, widths and reset values.
`default_nettype none

module vrwm_cfg_regs import vrwm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output cfg_regs_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_steps    <= RAMP_STEPS_RST;
      cfg.min_lin_step  <= MIN_STEP_RST;
      cfg.min_ang_step  <= MIN_STEP_RST;
      cfg.left_gain     <= GAIN_ONE;
      cfg.right_gain    <= GAIN_ONE;
      cfg.turn_coupling <= GAIN_ONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RAMP_STEPS:    cfg.ramp_steps    <= cfg_data[RAMP_WIDTH-1:0];
        CFG_MIN_LIN_STEP:  cfg.min_lin_step  <= cfg_data[MIN_STEP_WIDTH-1:0];
        CFG_MIN_ANG_STEP:  cfg.min_ang_step  <= cfg_data[MIN_STEP_WIDTH-1:0];
        CFG_LEFT_GAIN:     cfg.left_gain     <= cfg_data[GAIN_WIDTH-1:0];
        CFG_RIGHT_GAIN:    cfg.right_gain    <= cfg_data[GAIN_WIDTH-1:0];
        CFG_TURN_COUPLING: cfg.turn_coupling <= cfg_data[GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vrwm_arith_unit.sv
// Shared bit-serial arithmetic unit: shift-add multiplier (one multiplier bit per
// cycle) and restoring divider (one quotient bit per cycle) on one adder. Uses vrwm_pkg.
`default_nettype none

module vrwm_arith_unit import vrwm_pkg::*; #(
  parameter int unsigned MCAND_WIDTH = SPEED_WIDTH_DEF + GAIN_WIDTH,
  parameter int unsigned DIVD_WIDTH  = SPEED_WIDTH_DEF + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  arith_cmd_t                          cmd,
  input  logic [MCAND_WIDTH-1:0]              mcand,
  input  logic [GAIN_WIDTH-1:0]               mplier,
  input  logic [DIVD_WIDTH-1:0]               dividend,
  input  logic [RAMP_WIDTH-1:0]               divisor,
  output arith_stat_t                         stat,
  output logic [MCAND_WIDTH+GAIN_WIDTH-1:0]   prod
);

  localparam int unsigned PW      = MCAND_WIDTH + GAIN_WIDTH;
  localparam int unsigned AW      = MCAND_WIDTH + 1;
  localparam int unsigned LEN_MAX = (DIVD_WIDTH > GAIN_WIDTH) ? DIVD_WIDTH : GAIN_WIDTH;
  localparam int unsigned CW      = $clog2(LEN_MAX);

  logic [PW-1:0]          acc;
  logic [RAMP_WIDTH-1:0]  rem;
  logic [MCAND_WIDTH-1:0] opa;
  logic [RAMP_WIDTH-1:0]  opd;
  unit_mode_t             mode;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic                   done;

  logic [RAMP_WIDTH:0]    rem2;
  logic [AW-1:0]          add_x;
  logic [AW-1:0]          add_y;
  logic [AW-1:0]          sum;
  logic                   ge;

  assign rem2 = {rem, acc[DIVD_WIDTH-1]};

  always_comb begin
    if (mode == MODE_MUL) begin
      add_x = {1'b0, acc[PW-1:GAIN_WIDTH]};
      add_y = acc[0] ? {1'b0, opa} : '0;
    end else begin
      add_x = {{(AW-RAMP_WIDTH-1){1'b0}}, rem2};
      add_y = ~{{(AW-RAMP_WIDTH){1'b0}}, opd};
    end
  end

  assign sum = add_x + add_y + {{(AW-1){1'b0}}, (mode == MODE_DIV)};
  assign ge  = ~sum[AW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      mode <= MODE_MUL;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        mode <= cmd.mode;
        cnt  <= (cmd.mode == MODE_MUL) ? CW'(GAIN_WIDTH - 1) : CW'(DIVD_WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      opa <= mcand;
      opd <= divisor;
      rem <= '0;
      if (cmd.mode == MODE_MUL) begin
        acc <= {{MCAND_WIDTH{1'b0}}, mplier};
      end else begin
        acc <= {{(PW-DIVD_WIDTH){1'b0}}, dividend};
      end
    end else if (busy) begin
      if (mode == MODE_MUL) begin
        acc <= {sum, acc[GAIN_WIDTH-1:1]};
      end else begin
        acc <= {acc[PW-1:DIVD_WIDTH], acc[DIVD_WIDTH-2:0], ge};
        rem <= ge ? sum[RAMP_WIDTH-1:0] : rem2[RAMP_WIDTH-1:0];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign prod      = acc;

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking bench for velocity_ramp_wheel_mixer_core: set/tick words, config writes,
// an in-bench ramp and wheel-mix predictor, and a checker for every output word.
// Depends on vrwm_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vrwm_pkg::*;

  typedef logic signed [SPEED_WIDTH_DEF-1:0] speed_t;
  typedef logic signed [SPEED_WIDTH_DEF+1:0] speed_diff_t;
  typedef logic signed [49:0] mix_t;
  typedef struct {
    speed_t left;
    speed_t right;
  } wheel_refs_t;

  localparam int IDLE_PCT     = 19;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_WORDS = 1030;

  localparam speed_t SPEED_MAX = 24'sh7FFFFF;
  localparam speed_t SPEED_MIN = 24'sh800000;
  localparam logic [RAMP_WIDTH-1:0]      RAMP_MAX     = '1;
  localparam logic [MIN_STEP_WIDTH-1:0]  MIN_STEP_MAX = '1;
  localparam logic [GAIN_WIDTH-1:0]      GAIN_MAX     = '1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = OP_SET;
  logic signed [IN_WIDTH-1:0] target_lin = '0;
  logic signed [IN_WIDTH-1:0] target_ang = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [REF_WIDTH-1:0] left_ref;
  logic signed [REF_WIDTH-1:0] right_ref;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  int idle_pct = IDLE_PCT;
  int errors = 0;

  cfg_regs_t cfg_now = '{RAMP_STEPS_RST, MIN_STEP_RST, MIN_STEP_RST, GAIN_ONE, GAIN_ONE, GAIN_ONE};
  speed_t lin_now = '0;
  speed_t ang_now = '0;
  speed_t lin_goal = '0;
  speed_t ang_goal = '0;
  speed_t lin_inc = '0;
  speed_t ang_inc = '0;
  wheel_refs_t refs_due[$];

  velocity_ramp_wheel_mixer_core u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= idle_pct);

  function automatic speed_t clamp_speed(speed_diff_t x);
    if (x > 26'sd8388607) return SPEED_MAX;
    if (x < -26'sd8388608) return SPEED_MIN;
    return speed_t'(x);
  endfunction

  function automatic speed_t plan_step(speed_t goal, speed_t cur,
                                       logic [MIN_STEP_WIDTH-1:0] floor_mag);
    speed_diff_t diff, q, span, lo;
    diff = speed_diff_t'(goal) - speed_diff_t'(cur);
    span = (cfg_now.ramp_steps == '0) ? speed_diff_t'(1)
                                      : speed_diff_t'({1'b0, cfg_now.ramp_steps});
    q = diff / span;
    lo = speed_diff_t'({1'b0, floor_mag});
    if (diff > 0 && q < lo) q = lo;
    if (diff < 0 && -q < lo) q = -lo;
    return clamp_speed(q);
  endfunction

  function automatic speed_t step_toward(speed_t cur, speed_t goal, speed_t inc);
    speed_diff_t gap, inc_mag;
    gap = speed_diff_t'(cur) - speed_diff_t'(goal);
    inc_mag = speed_diff_t'(inc);
    if (gap < 0) gap = -gap;
    if (inc_mag < 0) inc_mag = -inc_mag;
    if (gap <= inc_mag) return goal;
    return clamp_speed(speed_diff_t'(cur) + speed_diff_t'(inc));
  endfunction

  // mix is Q24 speed; times Q16 gain, truncate toward zero, saturate
  function automatic speed_t wheel_drive(mix_t mix, logic [GAIN_WIDTH-1:0] gain);
    logic [49:0] m;
    logic [79:0] prod;
    logic [39:0] whole;
    m = (mix < 0) ? -mix : mix;
    prod = {30'b0, m} * {56'b0, gain};
    whole = prod[79:40];
    if (mix < 0) return (whole > 40'h800000) ? SPEED_MIN : speed_t'(-whole);
    return (whole > 40'h7FFFFF) ? SPEED_MAX : speed_t'(whole);
  endfunction

  function automatic void take_word(logic word_op, speed_t lin, speed_t ang);
    mix_t v_term, w_term;
    wheel_refs_t due;
    if (word_op == OP_SET) begin
      lin_goal = lin;
      ang_goal = ang;
      lin_inc = plan_step(lin_goal, lin_now, cfg_now.min_lin_step);
      ang_inc = plan_step(ang_goal, ang_now, cfg_now.min_ang_step);
      return;
    end
    lin_now = step_toward(lin_now, lin_goal, lin_inc);
    ang_now = step_toward(ang_now, ang_goal, ang_inc);
    v_term = lin_now;
    v_term = v_term <<< 16;
    w_term = ang_now * $signed({1'b0, cfg_now.turn_coupling});
    due.left = wheel_drive(w_term - v_term, cfg_now.left_gain);
    due.right = wheel_drive(v_term + w_term, cfg_now.right_gain);
    refs_due.push_back(due);
  endfunction

  always @(posedge clk) begin
    wheel_refs_t due;
    if (!rst && out_valid && out_ready) begin
      if (refs_due.size() == 0) begin
        $error("output word with none predicted: left_ref %0d right_ref %0d",
               left_ref, right_ref);
        errors++;
      end else begin
        due = refs_due.pop_front();
        if (left_ref !== due.left) begin
          $error("left_ref mismatch: expected %0d, actual %0d", due.left, left_ref);
          errors++;
        end
        if (right_ref !== due.right) begin
          $error("right_ref mismatch: expected %0d, actual %0d", due.right, right_ref);
          errors++;
        end
      end
    end
  end

  // leaves in_valid high; the next call or drain() decides what it does next
  task automatic send_word(logic word_op, speed_t lin, speed_t ang);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= word_op;
    target_lin <= lin;
    target_ang <= ang;
    do @(posedge clk); while (!in_ready);
    take_word(word_op, lin, ang);
  endtask

  task automatic tick_once();
    send_word(OP_TICK, speed_t'($urandom), speed_t'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (refs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RAMP_STEPS:    cfg_now.ramp_steps = val[RAMP_WIDTH-1:0];
      CFG_MIN_LIN_STEP:  cfg_now.min_lin_step = val[MIN_STEP_WIDTH-1:0];
      CFG_MIN_ANG_STEP:  cfg_now.min_ang_step = val[MIN_STEP_WIDTH-1:0];
      CFG_LEFT_GAIN:     cfg_now.left_gain = val[GAIN_WIDTH-1:0];
      CFG_RIGHT_GAIN:    cfg_now.right_gain = val[GAIN_WIDTH-1:0];
      CFG_TURN_COUPLING: cfg_now.turn_coupling = val[GAIN_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic program_cfg(cfg_regs_t c);
    drain();
    cfg_write(CFG_RAMP_STEPS, CFG_DATA_WIDTH'(c.ramp_steps));
    cfg_write(CFG_MIN_LIN_STEP, CFG_DATA_WIDTH'(c.min_lin_step));
    cfg_write(CFG_MIN_ANG_STEP, CFG_DATA_WIDTH'(c.min_ang_step));
    cfg_write(CFG_LEFT_GAIN, CFG_DATA_WIDTH'(c.left_gain));
    cfg_write(CFG_RIGHT_GAIN, CFG_DATA_WIDTH'(c.right_gain));
    cfg_write(CFG_TURN_COUPLING, CFG_DATA_WIDTH'(c.turn_coupling));
    cfg_valid <= 1'b0;
  endtask

  function automatic speed_t random_target();
    case ($urandom_range(9))
      0, 1, 2: return speed_t'(int'($urandom_range(8192)) - 4096);
      3:       return $urandom_range(1) ? SPEED_MAX : SPEED_MIN;
      default: return speed_t'($urandom);
    endcase
  endfunction

  function automatic logic [MIN_STEP_WIDTH-1:0] random_floor();
    case ($urandom_range(7))
      0:       return MIN_STEP_MAX;
      1:       return MIN_STEP_WIDTH'($urandom_range(1, 8388607));
      default: return MIN_STEP_WIDTH'($urandom_range(1, 256));
    endcase
  endfunction

  function automatic logic [GAIN_WIDTH-1:0] random_gain();
    case ($urandom_range(9))
      0:       return '0;
      1:       return GAIN_MAX;
      2:       return GAIN_ONE;
      3, 4:    return GAIN_WIDTH'($urandom);
      default: return GAIN_WIDTH'($urandom_range(131072));
    endcase
  endfunction

  task automatic test_default_ramp();
    send_word(OP_SET, 24'sd1000, -24'sd500);
    repeat (3) tick_once();
  endtask

  // ramp_steps of zero acts as one; full-scale swings saturate the step
  task automatic test_zero_ramp_full_swing();
    program_cfg('{16'd0, 23'd1, 23'd1, GAIN_ONE, GAIN_ONE, GAIN_ONE});
    send_word(OP_SET, SPEED_MAX, SPEED_MIN);
    repeat (2) tick_once();
    send_word(OP_SET, SPEED_MIN, SPEED_MAX);
    repeat (3) tick_once();
  endtask

  task automatic test_ref_saturation();
    program_cfg('{16'd1, 23'd1, 23'd1, GAIN_MAX, GAIN_MAX, GAIN_MAX});
    tick_once();
    send_word(OP_SET, SPEED_MAX, SPEED_MAX);
    tick_once();
    send_word(OP_SET, 24'sd0, 24'sd0);
    tick_once();
    program_cfg('{16'd1, 23'd1, 23'd1, 24'd0, 24'd0, 24'd0});
    send_word(OP_SET, SPEED_MIN, 24'sd1);
    tick_once();
  endtask

  task automatic test_min_step_floor();
    program_cfg('{RAMP_MAX, MIN_STEP_MAX, 23'd1, GAIN_ONE, GAIN_ONE, GAIN_ONE});
    send_word(OP_SET, 24'sd256, -24'sd70000);
    repeat (2) tick_once();
    send_word(OP_SET, -24'sd256, 24'sd0);
    tick_once();
  endtask

  task automatic test_spare_index();
    drain();
    cfg_write(CFG_SPARE_LO, '1);
    cfg_write(CFG_SPARE_HI, CFG_DATA_WIDTH'(1));
    cfg_valid <= 1'b0;
    tick_once();
  endtask

  task automatic test_random_ramps();
    int sent;
    int burst;
    cfg_regs_t c;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      idle_pct = (sent >= 400 && sent < 600) ? 0 : IDLE_PCT;
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0:       c.ramp_steps = '0;
          1:       c.ramp_steps = RAMP_MAX;
          2:       c.ramp_steps = RAMP_WIDTH'($urandom_range(65535));
          default: c.ramp_steps = RAMP_WIDTH'($urandom_range(1, 16));
        endcase
        c.min_lin_step = random_floor();
        c.min_ang_step = random_floor();
        c.left_gain = random_gain();
        c.right_gain = random_gain();
        c.turn_coupling = random_gain();
        program_cfg(c);
      end
      burst = $urandom_range(1, 24);
      send_word(OP_SET, random_target(), random_target());
      sent++;
      repeat (burst) begin
        if ($urandom_range(9) == 0)
          send_word(1'($urandom_range(1)), random_target(), random_target());
        else
          send_word(OP_TICK, random_target(), random_target());
        sent++;
      end
    end
    idle_pct = IDLE_PCT;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_default_ramp();
    test_zero_ramp_full_swing();
    test_ref_saturation();
    test_min_step_floor();
    test_spare_index();
    test_random_ramps();
    drain();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
